### src/wls_pkg.sv
// ---------------------------------------------------------------------------
// Windowed load sampler package
// Shared types and constants for the sampler modules.
// ---------------------------------------------------------------------------
package wls_pkg;

	localparam int unsigned MS_PER_S = 1000;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DISABLED = 2'd1,
		ST_ZERO_WIN = 2'd2
	} status_t;

	localparam logic KIND_COLLECT = 1'b0;
	localparam logic KIND_QUERY   = 1'b1;

	localparam logic CFG_SAMPLE_COUNT    = 1'b0;
	localparam logic CFG_SAMPLE_INTERVAL = 1'b1;

	// Request from the controller to the fraction divider.
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
		logic [5:0]  den_bits;
		logic [31:0] lim;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
	} div_rsp_t;

endpackage

### src/wls_frac_div.sv
// ---------------------------------------------------------------------------
// Fractional divider
// Computes floor(num * 2^16 / den) saturated at lim, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module wls_frac_div (
	input  logic              clk,
	input  logic              arst_n,
	input  wls_pkg::div_req_t req,
	output wls_pkg::div_rsp_t rsp
);
	import wls_pkg::*;

	// Restoring division of num << 16. Only the low 33
	// quotient bits are kept; a sticky flag records any higher set bit,
	// which always means the result is above lim.
	logic [79:0] dvd_q;
	logic [63:0] rem_q;
	logic [63:0] den_q;
	logic [32:0] quo_q;
	logic        sat_q;
	logic [31:0] lim_q;
	logic [6:0]  cnt_q;
	logic        busy_q;

	logic [64:0] shifted;
	logic [64:0] diff;
	logic        ge;
	logic [32:0] quo_n;
	logic        sat_n;

	assign shifted = {rem_q, dvd_q[79]};
	assign ge      = (shifted >= {1'b0, den_q});
	assign diff    = shifted - {1'b0, den_q};
	assign quo_n   = {quo_q[31:0], ge};
	assign sat_n   = sat_q | quo_q[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rsp    <= '0;
		end else begin
			rsp.done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd79;
				dvd_q  <= {req.num, 16'd0};
				rem_q  <= '0;
				den_q  <= req.den;
				lim_q  <= req.lim;
				quo_q  <= '0;
				sat_q  <= 1'b0;
			end else if (busy_q) begin
				rem_q <= ge ? diff[63:0] : shifted[63:0];
				dvd_q <= {dvd_q[78:0], 1'b0};
				quo_q <= quo_n;
				sat_q <= sat_n;
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd0) begin
					busy_q   <= 1'b0;
					rsp.done <= 1'b1;
					rsp.quo  <= (sat_n || quo_n > {1'b0, lim_q}) ? lim_q : quo_n[31:0];
				end
			end
		end
	end

	logic unused;
	assign unused = ^{req.den_bits};
endmodule

### src/wls_ctrl.sv
// ---------------------------------------------------------------------------
// Sampler controller
// Ring memory, collect read-modify-write, empty-sample fill and query walk.
// ---------------------------------------------------------------------------
module wls_ctrl #(
	parameter int unsigned RING_DEPTH = 64,
	parameter int unsigned TIME_BITS  = 48,
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_idx,
	input  logic [11:0]           cfg_data,
	input  logic                  in_go,
	input  logic                  in_kind,
	input  logic [TIME_BITS-1:0]  in_begin,
	input  logic [TIME_BITS-1:0]  in_end,
	input  logic [31:0]           in_budget,
	input  logic [TIME_BITS-1:0]  in_window,
	output logic                  idle,
	output logic                  res_valid,
	output logic [1:0]            res_status,
	output logic [TIME_BITS-1:0]  res_cov,
	output logic [TIME_BITS-1:0]  res_busy,
	output logic [COUNT_BITS-1:0] res_fr,
	output logic [COUNT_BITS-1:0] res_ov,
	output logic [23:0]           res_load,
	output logic [16:0]           res_orate,
	output wls_pkg::div_req_t     dreq,
	input  wls_pkg::div_rsp_t     drsp
);
	import wls_pkg::*;

	localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned CW = $clog2(RING_DEPTH + 1);
	localparam int unsigned SW = 2 * TIME_BITS + 2 * COUNT_BITS;
	localparam logic [TIME_BITS-1:0]  TMAX = '1;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CRD   = 9'b000000010,
		S_CMOD  = 9'b000000100,
		S_DIVQ  = 9'b000001000,
		S_FILL  = 9'b000010000,
		S_QRD   = 9'b000100000,
		S_QACC  = 9'b001000000,
		S_LDIV  = 9'b010000000,
		S_ODIV  = 9'b100000000
	} state_t;

	typedef struct packed {
		logic [TIME_BITS-1:0]  b;
		logic [TIME_BITS-1:0]  l;
		logic [TIME_BITS-1:0]  busy;
		logic [COUNT_BITS-1:0] fr;
		logic [COUNT_BITS-1:0] ov;
	} slot_t;

	slot_t mem [RING_DEPTH];
	slot_t rd_q, wr_d;
	logic  we;
	logic [AW-1:0] wa, ra;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wr_d;
		rd_q <= mem[ra];
	end

	state_t state_q;
	logic [6:0]  count_q;
	logic [11:0] ivs_q;
	logic [AW-1:0] newest_q, idx_q;
	logic [CW-1:0] filled_q, walk_q, skip_q;
	logic [TIME_BITS-1:0] beg_q, end_q, win_q, busyf_q, t_q, ivl_q;
	logic over_q;
	logic [TIME_BITS-1:0]  cov_q, bsum_q;
	logic [COUNT_BITS-1:0] fsum_q, osum_q;
	logic [23:0] load_q;

	logic [CW-1:0] cap;
	assign cap = (32'(count_q) > RING_DEPTH) ? CW'(RING_DEPTH) : CW'(count_q);

	function automatic logic [TIME_BITS-1:0] tadd(input logic [TIME_BITS-1:0] a,
		input logic [TIME_BITS-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
	endfunction

	function automatic logic [COUNT_BITS-1:0] cadd(input logic [COUNT_BITS-1:0] a,
		input logic [COUNT_BITS-1:0] b);
		logic [COUNT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_BITS] ? CMAX : s[COUNT_BITS-1:0];
	endfunction

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i, input logic [CW-1:0] c);
		logic [CW:0] s;
		s = {1'b0, CW'(i)} + (CW+1)'(1);
		return (s >= {1'b0, c}) ? '0 : s[AW-1:0];
	endfunction

	// Next newest slot and fill count after pushing one sample.
	logic [AW-1:0] push_idx;
	logic [CW-1:0] push_fill;
	assign push_idx  = (filled_q == '0) ? '0 : nxt(newest_q, cap);
	assign push_fill = (filled_q < cap) ? filled_q + CW'(1) : filled_q;

	logic [TIME_BITS-1:0] span, elapsed, busy_in;
	assign span    = (rd_q.l > rd_q.b) ? rd_q.l - rd_q.b : '0;
	assign elapsed = end_q - rd_q.b;
	assign busy_in = (in_end >= in_begin) ? in_end - in_begin : '0;

	logic [TIME_BITS-1:0] cov_n;
	assign cov_n = tadd(cov_q, span);

	always_comb begin
		ra   = idx_q;
		we   = 1'b0;
		wa   = push_idx;
		wr_d = '0;
		dreq = '0;
		unique case (state_q)
			S_CMOD: begin
				we        = 1'b1;
				wa        = newest_q;
				wr_d      = rd_q;
				wr_d.l    = end_q;
				wr_d.busy = tadd(rd_q.busy, busyf_q);
				wr_d.fr   = cadd(rd_q.fr, COUNT_BITS'(1));
				if (over_q) wr_d.ov = cadd(rd_q.ov, COUNT_BITS'(1));
			end
			S_FILL: begin
				we   = 1'b1;
				if (filled_q == '0) begin
					// An empty ring is seeded with the frame itself.
					wr_d.b    = beg_q;
					wr_d.l    = end_q;
					wr_d.busy = busyf_q;
					wr_d.fr   = COUNT_BITS'(1);
					wr_d.ov   = COUNT_BITS'(over_q);
				end else if (skip_q != '0) begin
					wr_d.b = t_q;
					wr_d.l = t_q + ivl_q;
				end else begin
					wr_d.b = end_q;
					wr_d.l = end_q;
				end
			end
			default: ;
		endcase
		if (state_q == S_CMOD && !(end_q < rd_q.b) && elapsed >= ivl_q) begin
			dreq.start    = 1'b1;
			dreq.num      = 64'(elapsed);
			dreq.den      = 64'(ivl_q);
			dreq.den_bits = '0;
			dreq.lim      = '1;
		end
		if (state_q == S_QACC && !(walk_q != '0 && cov_n < win_q && walk_q != CW'(1))) begin
			dreq.start = (cov_n != '0);
			dreq.num   = 64'(tadd(bsum_q, rd_q.busy));
			dreq.den   = 64'(cov_n);
			dreq.lim   = 32'hFFFFFF;
		end
		if (state_q == S_LDIV && (drsp.done || cov_q == '0)) begin
			dreq.start = (fsum_q != '0);
			dreq.num   = 64'(osum_q);
			dreq.den   = 64'(fsum_q);
			dreq.lim   = 32'h10000;
		end
	end

	// The divider yields floor(elapsed*2^16/ivl); the skip count is its
	// integer part minus one. A capped quotient still has an integer part
	// above the ring size, which is all that matters here.
	logic [CW:0] whole;
	assign whole = (drsp.quo[31:16] > 16'(RING_DEPTH + 1)) ?
	               (CW+1)'(RING_DEPTH + 1) : (CW+1)'(drsp.quo[31:16]);

	assign idle = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			ivs_q     <= 12'd1;
			newest_q  <= '0;
			filled_q  <= '0;
			res_valid <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			if (cfg_we) begin
				if (cfg_idx == CFG_SAMPLE_COUNT) count_q <= cfg_data[6:0];
				else ivs_q <= cfg_data;
				newest_q <= '0;
				filled_q <= '0;
			end
			unique case (state_q)
				S_IDLE: if (in_go) begin
					beg_q   <= in_begin;
					end_q   <= in_end;
					win_q   <= in_window;
					busyf_q <= busy_in;
					over_q  <= (in_budget != '0) && (busy_in >= TIME_BITS'(in_budget));
					ivl_q   <= TIME_BITS'((ivs_q == '0) ? 12'd1 : ivs_q) *
					           TIME_BITS'(MS_PER_S);
					idx_q   <= newest_q;
					cov_q   <= '0; bsum_q <= '0; fsum_q <= '0; osum_q <= '0;
					load_q  <= '0;
					walk_q  <= (filled_q < cap) ? filled_q : cap;
					if (in_kind == KIND_COLLECT) begin
						if (cap == '0) begin
							// Disabled: nothing to do.
						end else if (filled_q == '0) begin
							skip_q <= '0;
							t_q    <= '0;
							state_q <= S_FILL;
						end else state_q <= S_CRD;
					end else begin
						if (cap == '0 || in_window == '0) begin
							res_valid  <= 1'b1;
							res_status <= (cap == '0) ? ST_DISABLED : ST_ZERO_WIN;
							res_cov <= '0; res_busy <= '0; res_fr <= '0; res_ov <= '0;
							res_load <= '0; res_orate <= '0;
						end else if (filled_q == '0) begin
							state_q <= S_LDIV;
						end else state_q <= S_QRD;
					end
				end
				S_CRD:  state_q <= S_CMOD;
				S_CMOD: begin
					t_q <= rd_q.b + ivl_q;
					if (dreq.start) state_q <= S_DIVQ;
					else state_q <= S_IDLE;
				end
				S_DIVQ: if (drsp.done) begin
					skip_q  <= ((whole - (CW+1)'(1)) > (CW+1)'(cap)) ?
					           cap : CW'(whole - (CW+1)'(1));
					state_q <= S_FILL;
				end
				S_FILL: begin
					newest_q <= push_idx;
					filled_q <= push_fill;
					if (skip_q != '0) begin
						skip_q <= skip_q - CW'(1);
						t_q    <= t_q + ivl_q;
					end else state_q <= S_IDLE;
				end
				S_QRD: state_q <= S_QACC;
				S_QACC: begin
					cov_q  <= cov_n;
					bsum_q <= tadd(bsum_q, rd_q.busy);
					fsum_q <= cadd(fsum_q, rd_q.fr);
					osum_q <= cadd(osum_q, rd_q.ov);
					walk_q <= walk_q - CW'(1);
					idx_q  <= (idx_q == '0) ? AW'(cap - CW'(1)) : idx_q - AW'(1);
					if (cov_n >= win_q || walk_q == CW'(1)) state_q <= S_LDIV;
					else state_q <= S_QRD;
				end
				S_LDIV: if (drsp.done || cov_q == '0) begin
					load_q <= (cov_q == '0) ? '0 : drsp.quo[23:0];
					if (fsum_q == '0) begin
						res_valid <= 1'b1;
						res_status <= ST_OK;
						res_cov <= cov_q; res_busy <= bsum_q;
						res_fr <= fsum_q; res_ov <= osum_q;
						res_load <= (cov_q == '0) ? '0 : drsp.quo[23:0];
						res_orate <= '0;
						state_q <= S_IDLE;
					end else state_q <= S_ODIV;
				end
				S_ODIV: if (drsp.done) begin
					res_valid <= 1'b1;
					res_status <= ST_OK;
					res_cov <= cov_q; res_busy <= bsum_q;
					res_fr <= fsum_q; res_ov <= osum_q;
					res_load <= load_q;
					res_orate <= drsp.quo[16:0];
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### src/windowed_load_sampler.sv
// ---------------------------------------------------------------------------
// Windowed load sampler
// Ring of per-interval load samples with collect and windowed query words.
// ---------------------------------------------------------------------------
// Usage: input words arrive on the s_axis group. tuser carries the kind
// (collect or query); tdata carries begin_ms, end_ms, frame_budget_ms and
// window_ms from the lowest bit up. A query produces one result word on the
// m_axis group; a collect produces none. Configuration goes through the
// cfg_we / cfg_idx / cfg_data write port and clears the ring.
// The sample ring sits in one synchronous memory with a registered read, so a
// collect reads, modifies and writes back the newest slot.
// A collect keeps the input blocked until it is done; the first collect
// seeds the ring with a single write. When an interval expires the skip
// count comes from the shared fraction divider, then each empty sample and
// finally the new sample are written in turn.
// A query reads the slots newest first (at most RING_DEPTH of them) and then
// uses up to two divider passes, one for the load rate and one for the
// overload rate, before the result word shows up; an error status skips the
// walk and the divider.
// One word is worked on at a time; s_axis_tready is high only while the
// controller is idle, no result is on its way out and the result register
// is free. A stalled receiver holds the result in the output register and
// stops new input.
// Reset clears the ring pointers, the configuration and the control state; the slot memory itself
// is not cleared, as only written slots are ever read.
// ---------------------------------------------------------------------------
module windowed_load_sampler #(
	parameter int unsigned RING_DEPTH = 64,
	parameter int unsigned TIME_BITS  = 48,
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [11:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// begin_ms, end_ms, frame_budget_ms, window_ms (lowest bits first)
	input  logic [((3*TIME_BITS+32+7)/8)*8-1:0] s_axis_tdata,
	// kind
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status, covered_ms, busy_ms, frame_total, overload_total, load_rate,
	// overload_rate (lowest bits first)
	output logic [((2+2*TIME_BITS+2*COUNT_BITS+41+7)/8)*8-1:0] m_axis_tdata
);
	import wls_pkg::*;

	localparam int unsigned OW = ((2+2*TIME_BITS+2*COUNT_BITS+41+7)/8)*8;
	localparam int unsigned PW = 2+2*TIME_BITS+2*COUNT_BITS+41;

	logic idle, res_valid;
	logic [1:0] res_status;
	logic [TIME_BITS-1:0] res_cov, res_busy;
	logic [COUNT_BITS-1:0] res_fr, res_ov;
	logic [23:0] res_load;
	logic [16:0] res_orate;
	div_req_t dreq;
	div_rsp_t drsp;

	logic in_go;
	// A result on its way into the output register also blocks input, so a
	// quick error result cannot overwrite a word the receiver has not taken.
	assign s_axis_tready = idle && !m_axis_tvalid && !res_valid;
	assign in_go = s_axis_tvalid && s_axis_tready;

	wls_ctrl #(.RING_DEPTH(RING_DEPTH), .TIME_BITS(TIME_BITS), .COUNT_BITS(COUNT_BITS))
	u_ctrl (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data,
		.in_go,
		.in_kind  (s_axis_tuser),
		.in_begin (s_axis_tdata[TIME_BITS-1:0]),
		.in_end   (s_axis_tdata[2*TIME_BITS-1:TIME_BITS]),
		.in_budget(s_axis_tdata[2*TIME_BITS+31:2*TIME_BITS]),
		.in_window(s_axis_tdata[3*TIME_BITS+31:2*TIME_BITS+32]),
		.idle, .res_valid, .res_status, .res_cov, .res_busy, .res_fr, .res_ov,
		.res_load, .res_orate, .dreq, .drsp
	);

	wls_frac_div u_div (.clk, .arst_n, .req(dreq), .rsp(drsp));

	// Output register: holds the result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else begin
			if (res_valid) begin
				m_axis_tvalid <= 1'b1;
				m_axis_tdata  <= OW'({res_orate, res_load, res_ov, res_fr,
				                      res_busy, res_cov, res_status});
			end else if (m_axis_tready) m_axis_tvalid <= 1'b0;
		end
	end

	logic unused;
	assign unused = ^{PW[0], s_axis_tdata};
endmodule

### src/wls_checker.sv
// ---------------------------------------------------------------------------
// Windowed load sampler checker
// Port-level assertions, attached to the top level by bind.
// ---------------------------------------------------------------------------
module wls_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic s_axis_tuser,
	input logic m_axis_tvalid,
	input logic m_axis_tready
);
	// A held result blocks new input.
	a_no_accept_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result held");
	// A collect never produces a result on the next edge.
	a_collect_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> !m_axis_tvalid)
		else $error("collect produced a result");
	// A stalled result stays valid.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
	// An accepted query leaves the input not ready in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
		else $error("no busy cycle");
endmodule

bind windowed_load_sampler wls_checker u_chk (.*);

### bench/tb_windowed_load_sampler.sv
// ---------------------------------------------------------------------------
// Windowed load sampler testbench
// Drives collect and query words into the sampler under several ring sizes
// and interval lengths, predicts every query result with a behavioral copy
// of the sample ring, and checks each result word against the prediction.
// ---------------------------------------------------------------------------
module tb_windowed_load_sampler;
	import wls_pkg::*;

	localparam int unsigned DEPTH = 64;
	localparam logic [63:0] TIME_LIM = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] COUNT_LIM = 64'hFFFF_FFFF;
	localparam logic [63:0] LOAD_LIM = 64'hFF_FFFF;
	localparam logic [63:0] OVL_LIM = 64'h1_0000;
	// A query walks up to a full ring of slots plus two divider passes; a
	// collect can add a full ring of empty samples. This covers both.
	localparam int unsigned SETTLE_CYCLES = 500;

	// Laid out like the result word: status in the lowest bits.
	typedef struct packed {
		logic [16:0] overload_rate;
		logic [23:0] load_rate;
		logic [31:0] overload_total;
		logic [31:0] frame_total;
		logic [47:0] busy_ms;
		logic [47:0] covered_ms;
		status_t     status;
	} load_report_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_idx;
	logic [11:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [175:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [207:0] m_axis_tdata;

	windowed_load_sampler dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Shadow copy of the sampler: registers and the sample ring.
	logic [6:0]  shadow_count;
	logic [11:0] shadow_interval_s;
	logic [63:0] ring_begin[DEPTH];
	logic [63:0] ring_last[DEPTH];
	logic [63:0] ring_busy[DEPTH];
	logic [63:0] ring_frames[DEPTH];
	logic [63:0] ring_overloads[DEPTH];
	int unsigned ring_newest;
	int unsigned ring_filled;

	load_report_t pending_reports[$];
	int unsigned mismatch_count;

	// Idle percentages for sender and receiver, and the receiver hold-off.
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	longint unsigned rx_cycle;
	longint unsigned rx_hold_end;

	// Stream of plausible frame times used by the well-formed traffic.
	logic [47:0] clock_now_ms;

	function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b,
			logic [63:0] lim);
		if (a > lim)
			a = lim;
		if (b > lim - a)
			return lim;
		return a + b;
	endfunction

	function automatic int unsigned ring_capacity();
		return (shadow_count > DEPTH) ? DEPTH : shadow_count;
	endfunction

	function automatic logic [63:0] interval_len_ms();
		logic [63:0] secs;
		secs = (shadow_interval_s == 0) ? 64'd1 : 64'(shadow_interval_s);
		return secs * MS_PER_S;
	endfunction

	// Truncated num/den in 16 fraction bits, saturated at lim.
	function automatic logic [63:0] ratio_q16(logic [63:0] num, logic [63:0] den,
			logic [63:0] lim);
		logic [63:0] q;
		logic [63:0] rem;
		q = num / den;
		rem = num % den;
		if (q > (lim >> 16))
			return lim;
		for (int i = 0; i < 16; i++) begin
			q = q << 1;
			if (rem >= den - rem) begin
				rem = rem - (den - rem);
				q[0] = 1'b1;
			end else begin
				rem = rem + rem;
			end
		end
		return (q > lim) ? lim : q;
	endfunction

	function automatic void ring_push(logic [63:0] b, logic [63:0] l, logic [63:0] busy,
			logic [63:0] fr, logic [63:0] ov);
		int unsigned cap;
		cap = ring_capacity();
		if (cap == 0)
			return;
		ring_newest = (ring_filled == 0) ? 0 : (ring_newest + 1) % cap;
		if (ring_filled < cap)
			ring_filled++;
		ring_begin[ring_newest] = b;
		ring_last[ring_newest] = l;
		ring_busy[ring_newest] = busy;
		ring_frames[ring_newest] = fr;
		ring_overloads[ring_newest] = ov;
	endfunction

	function automatic void record_frame(logic [47:0] b_ms, logic [47:0] e_ms,
			logic [31:0] budget);
		int unsigned cap;
		int unsigned n;
		logic [63:0] busy;
		logic [63:0] ivl;
		logic [63:0] elapsed;
		logic [63:0] skipped;
		logic [63:0] t;
		logic over;
		cap = ring_capacity();
		if (cap == 0)
			return;
		busy = (e_ms >= b_ms) ? 64'(e_ms - b_ms) : 64'd0;
		over = (budget != 0) && (busy >= 64'(budget));
		if (ring_filled == 0) begin
			ring_push(b_ms, e_ms, busy, 1, over);
			return;
		end
		n = ring_newest % cap;
		ring_last[n] = e_ms;
		ring_busy[n] = sat_sum(ring_busy[n], busy, TIME_LIM);
		ring_frames[n] = sat_sum(ring_frames[n], 1, COUNT_LIM);
		if (over)
			ring_overloads[n] = sat_sum(ring_overloads[n], 1, COUNT_LIM);
		// Time running backwards keeps the frame in the current sample.
		if (64'(e_ms) < ring_begin[n])
			return;
		elapsed = 64'(e_ms) - ring_begin[n];
		ivl = interval_len_ms();
		if (elapsed < ivl)
			return;
		// Whole intervals skipped become empty samples, at most a ring's worth.
		skipped = elapsed / ivl - 1;
		if (skipped > cap)
			skipped = cap;
		t = ring_begin[n] + ivl;
		for (logic [63:0] k = 0; k < skipped; k++) begin
			ring_push(t, t + ivl, 0, 0, 0);
			t += ivl;
		end
		ring_push(e_ms, e_ms, 0, 0, 0);
	endfunction

	function automatic load_report_t report_window(logic [47:0] window);
		load_report_t r;
		int unsigned cap;
		int unsigned idx;
		logic [63:0] span;
		logic [63:0] cov;
		logic [63:0] busy;
		logic [63:0] fr;
		logic [63:0] ov;
		r = '0;
		cap = ring_capacity();
		if (cap == 0) begin
			r.status = ST_DISABLED;
			return r;
		end
		if (window == 0) begin
			r.status = ST_ZERO_WIN;
			return r;
		end
		cov = 0;
		busy = 0;
		fr = 0;
		ov = 0;
		idx = ring_newest % cap;
		for (int unsigned i = 0; i < ring_filled && i < cap; i++) begin
			span = (ring_last[idx] > ring_begin[idx]) ? ring_last[idx] - ring_begin[idx] : 0;
			cov = sat_sum(cov, span, TIME_LIM);
			busy = sat_sum(busy, ring_busy[idx], TIME_LIM);
			fr = sat_sum(fr, ring_frames[idx], COUNT_LIM);
			ov = sat_sum(ov, ring_overloads[idx], COUNT_LIM);
			if (cov >= 64'(window))
				break;
			idx = (idx == 0) ? cap - 1 : idx - 1;
		end
		r.status = ST_OK;
		r.covered_ms = cov[47:0];
		r.busy_ms = busy[47:0];
		r.frame_total = fr[31:0];
		r.overload_total = ov[31:0];
		if (cov > 0)
			r.load_rate = 24'(ratio_q16(busy, cov, LOAD_LIM));
		if (fr > 0)
			r.overload_rate = 17'(ratio_q16(ov, fr, OVL_LIM));
		return r;
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Sends one word and waits for it to be accepted. tvalid is left high, so
	// back-to-back words keep it high; the next call or the caller lowers it.
	task automatic send_word(logic kind, logic [47:0] b_ms, logic [47:0] e_ms,
			logic [31:0] budget, logic [47:0] window);
		@(negedge clk);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = kind;
		s_axis_tdata = {window, budget, e_ms, b_ms};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (kind == KIND_COLLECT)
			record_frame(b_ms, e_ms, budget);
		else
			pending_reports.push_back(report_window(window));
	endtask

	task automatic collect_frame(logic [47:0] b_ms, logic [47:0] e_ms, logic [31:0] budget);
		send_word(KIND_COLLECT, b_ms, e_ms, budget, rand48());
	endtask

	task automatic query_load(logic [47:0] window);
		send_word(KIND_QUERY, rand48(), rand48(), $urandom, window);
	endtask

	// Waits for every outstanding result, then lets a trailing collect finish.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [11:0] value);
		drain();
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_SAMPLE_COUNT)
			shadow_count = value[6:0];
		else
			shadow_interval_s = value;
		ring_newest = 0;
		ring_filled = 0;
	endtask

	task automatic configure(logic [11:0] count, logic [11:0] interval_s);
		write_reg(CFG_SAMPLE_COUNT, count);
		write_reg(CFG_SAMPLE_INTERVAL, interval_s);
		clock_now_ms = 48'(1000 + $urandom_range(5000));
	endtask

	// With the ring disabled, collects are dropped and every query reports
	// disabled, even one with a zero window.
	task automatic test_disabled();
		collect_frame(48'd100, 48'd200, 32'd50);
		query_load(48'd1000);
		query_load(48'd0);
		query_load(TIME_LIM[47:0]);
	endtask

	// Directed corners: seeding, reversed frames, time running backwards,
	// zero window, long gaps that overrun the ring, busy-time saturation.
	task automatic test_directed_corners();
		configure(12'd4, 12'd1);
		query_load(48'd1000);
		collect_frame(48'd1000, 48'd1400, 32'd300);
		collect_frame(48'd1500, 48'd1450, 32'd0);
		collect_frame(48'd1600, 48'd1800, 32'hFFFF_FFFF);
		query_load(48'd0);
		query_load(48'd1);
		collect_frame(48'd2000, 48'd2300, 32'd100);
		collect_frame(48'd1000, 48'd500, 32'd1);
		collect_frame(48'd2300, 48'd50_000, 32'd10);
		query_load(48'd2500);
		query_load(TIME_LIM[47:0]);
		collect_frame(48'd0, TIME_LIM[47:0], 32'd1);
		collect_frame(48'd0, TIME_LIM[47:0], 32'd0);
		collect_frame(TIME_LIM[47:0], TIME_LIM[47:0], 32'd0);
		query_load(TIME_LIM[47:0]);
		// A count above the ring depth acts as the full ring; interval 0 as 1 s.
		configure(12'd100, 12'd0);
		collect_frame(48'd0, 48'd10, 32'd5);
		collect_frame(48'd10, 48'd200_000, 32'd5);
		query_load(TIME_LIM[47:0]);
		configure(12'd1, 12'd3600);
		collect_frame(48'd0, 48'd3_600_000, 32'd7);
		collect_frame(48'd3_600_000, 48'd3_600_005, 32'd7);
		query_load(48'd5);
		query_load(TIME_LIM[47:0]);
	endtask

	// One random word: mostly a plausible frame stream with queries mixed in,
	// some noise words with arbitrary fields.
	task automatic random_word();
		logic [63:0] ivl;
		logic [47:0] dur;
		logic [47:0] b_ms;
		logic [47:0] e_ms;
		logic [31:0] budget;
		int unsigned pick;
		ivl = interval_len_ms();
		pick = $urandom_range(99);
		if (pick < 5) begin
			b_ms = rand48();
			e_ms = rand48();
			collect_frame(b_ms, e_ms, $urandom);
			if (e_ms[47] == 1'b0)
				clock_now_ms = e_ms;
		end else if (pick < 8) begin
			query_load($urandom_range(3) == 0 ? 48'd0 : rand48());
		end else if (pick < 70) begin
			dur = 48'($urandom_range(0, 32'(ivl / 3)));
			if ($urandom_range(9) == 0)
				budget = 0;
			else if ($urandom_range(9) == 0)
				budget = $urandom;
			else
				budget = $urandom_range(1, 32'(ivl / 3) + 1);
			b_ms = clock_now_ms;
			e_ms = clock_now_ms + dur;
			if ($urandom_range(19) == 0) begin
				b_ms = e_ms;
				e_ms = e_ms - 48'($urandom_range(1, 500));
			end
			collect_frame(b_ms, e_ms, budget);
			clock_now_ms = clock_now_ms + dur + 48'($urandom_range(0, 32'(ivl / 2)));
			if ($urandom_range(24) == 0)
				clock_now_ms = clock_now_ms + 48'(ivl * $urandom_range(2, 80));
		end else begin
			query_load(48'($urandom_range(1, 32'(ivl * (ring_capacity() + 2)))));
		end
	endtask

	task automatic test_random_phase(logic [11:0] count, logic [11:0] interval_s,
			int unsigned words);
		configure(count, interval_s);
		for (int unsigned i = 0; i < words; i++)
			random_word();
	endtask

	// The receiver holds off for a long stretch while queries keep coming, so
	// the result register fills and the input stalls behind it.
	task automatic test_output_stall();
		configure(12'd8, 12'd2);
		collect_frame(48'd0, 48'd300, 32'd200);
		collect_frame(48'd2500, 48'd2600, 32'd200);
		rx_hold_end = rx_cycle + 3000;
		for (int i = 0; i < 12; i++)
			query_load(48'($urandom_range(1, 20_000)));
	endtask

	always @(negedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle < rx_hold_end)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Every accepted result word is held against the oldest pending report.
	always @(posedge clk) begin
		load_report_t got;
		load_report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[202:0];
			if (pending_reports.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result word %h", got);
			end else begin
				want = pending_reports.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: status %0d/%0d covered %0d/%0d busy %0d/%0d frames %0d/%0d overloads %0d/%0d load %h/%h overload %h/%h (expected/actual)",
							want.status, got.status, want.covered_ms, got.covered_ms,
							want.busy_ms, got.busy_ms, want.frame_total, got.frame_total,
							want.overload_total, got.overload_total,
							want.load_rate, got.load_rate,
							want.overload_rate, got.overload_rate);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_SAMPLE_COUNT;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = KIND_COLLECT;
		m_axis_tready = 1'b0;
		rx_cycle = 0;
		rx_hold_end = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		mismatch_count = 0;
		shadow_count = 0;
		shadow_interval_s = 1;
		ring_newest = 0;
		ring_filled = 0;
		clock_now_ms = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_disabled();
		test_directed_corners();
		test_output_stall();

		tx_idle_pct = 20;
		rx_idle_pct = 65;
		test_random_phase(12'd4, 12'd1, 300);
		tx_idle_pct = 65;
		rx_idle_pct = 20;
		test_random_phase(12'd64, 12'd1, 300);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_phase(12'd1, 12'd3600, 200);
		test_random_phase(12'($urandom_range(2, 127)), 12'($urandom_range(0, 4095)), 200);
		test_random_phase(12'($urandom_range(0, 4095)), 12'($urandom_range(1, 30)), 200);

		drain();
		if (mismatch_count == 0 && pending_reports.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
